// File: design/multiset_floor_take_unit_assert.svh
// ----------------------------------------------------------------------------
// multiset_floor_take_unit_assert.svh
// Assertion macros shared by the multiset floor-take unit. Each macro is
// sampled on i_clk and switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTISET_FLOOR_TAKE_UNIT_ASSERT_SVH
`define MULTISET_FLOOR_TAKE_UNIT_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define MFTU_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define MFTU_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: design/mftu_pkg.sv
// ----------------------------------------------------------------------------
// mftu_pkg
// Types, constants and helper functions for the multiset floor-take unit.
// ----------------------------------------------------------------------------
package mftu_pkg;

    localparam int C_CAPACITY   = 1024;
    localparam int C_VALUE_W    = 32;
    localparam int C_COUNT_W    = 11;
    localparam int C_STATUS_W   = 2;
    localparam int C_TREE_RADIX = 16;

    localparam logic [C_COUNT_W-1:0] C_COUNT_MAX = {C_COUNT_W{1'b1}};
    localparam logic [C_COUNT_W-1:0] C_COUNT_ONE = C_COUNT_W'(1);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_TAKE   = 1'b1
    } t_op;

    typedef enum logic [C_STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_TAKEN    = 2'd1,
        ST_NONE     = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INC,
        CMD_DEC,
        CMD_INSERT,
        CMD_REMOVE
    } t_cmd_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_PROBE,
        S_WAIT,
        S_UPD
    } t_state;

    // Broadcast from the controller to every cell of the chain.
    typedef struct packed {
        logic                 cmp;
        t_cmd_kind            kind;
        logic [C_VALUE_W-1:0] key;
    } t_ctrl;

    // Contents of one cell, as seen by its neighbours.
    typedef struct packed {
        logic                 valid;
        logic [C_VALUE_W-1:0] value;
        logic [C_COUNT_W-1:0] count;
    } t_slot;

    // What the hit cell reports; all other cells report zero.
    typedef struct packed {
        logic                 hit;
        logic                 eq;
        logic                 cmax;
        logic                 cone;
        logic [C_VALUE_W-1:0] value;
    } t_probe;

    // Number of nodes on a given level of the OR tree, level 0 being nearest the cells.
    function automatic int f_tree_nodes(input int level);
        int n;
        n = C_CAPACITY;
        for (int l = 0; l <= level; l++) begin
            n = (n + C_TREE_RADIX - 1) / C_TREE_RADIX;
        end
        return n;
    endfunction

    function automatic int f_tree_levels();
        int n;
        int l;
        n = (C_CAPACITY + C_TREE_RADIX - 1) / C_TREE_RADIX;
        l = 1;
        for (int k = 0; k < 8; k++) begin
            if (n > 1) begin
                n = (n + C_TREE_RADIX - 1) / C_TREE_RADIX;
                l = l + 1;
            end
        end
        return l;
    endfunction

    localparam int C_TREE_LEVELS = f_tree_levels();
    localparam int C_TREE_W0     = f_tree_nodes(0);

endpackage

// File: design/mftu_cell.sv
// ----------------------------------------------------------------------------
// mftu_cell
// One cell of the sorted chain: a distinct value, its copy count and the
// comparison flags taken against the current key.
// ----------------------------------------------------------------------------
module mftu_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mftu_pkg::t_ctrl  i_ctrl,
    input  mftu_pkg::t_slot  i_left,
    input  logic             i_left_le,
    input  mftu_pkg::t_slot  i_right,
    input  logic             i_right_le,
    output mftu_pkg::t_slot  o_slot,
    output logic             o_le,
    output logic             o_hit,
    output mftu_pkg::t_probe o_probe
);
    import mftu_pkg::*;

    logic                 r_valid, n_valid;
    logic [C_VALUE_W-1:0] r_value, n_value;
    logic [C_COUNT_W-1:0] r_count, n_count;
    logic                 r_le, n_le;
    logic                 r_eq, n_eq;
    logic                 w_hit;

    // The chain is kept in ascending order, so the last cell not above the
    // key is the one whose right neighbour is above it (or absent).
    assign w_hit = r_le && !i_right_le;

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_count = r_count;
        n_le    = r_le;
        n_eq    = r_eq;
        if (i_ctrl.cmp) begin
            n_le = r_valid && (r_value <= i_ctrl.key);
            n_eq = r_valid && (r_value == i_ctrl.key);
        end
        unique case (i_ctrl.kind)
            CMD_NONE: begin
            end
            CMD_INC: begin
                if (w_hit) begin
                    n_count = r_count + C_COUNT_ONE;
                end
            end
            CMD_DEC: begin
                if (w_hit) begin
                    n_count = r_count - C_COUNT_ONE;
                end
            end
            CMD_INSERT: begin
                // Cells above the key move up by one; the first of them takes the key.
                if (!r_le) begin
                    if (i_left_le) begin
                        n_valid = 1'b1;
                        n_value = i_ctrl.key;
                        n_count = C_COUNT_ONE;
                    end else begin
                        n_valid = i_left.valid;
                        n_value = i_left.value;
                        n_count = i_left.count;
                    end
                end
            end
            CMD_REMOVE: begin
                if (w_hit || !r_le) begin
                    n_valid = i_right.valid;
                    n_value = i_right.value;
                    n_count = i_right.count;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_le    <= 1'b0;
            r_eq    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_le    <= n_le;
            r_eq    <= n_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_count <= n_count;
    end

    assign o_slot.valid = r_valid;
    assign o_slot.value = r_value;
    assign o_slot.count = r_count;
    assign o_le         = r_le;
    assign o_hit        = w_hit;

    always_comb begin
        o_probe = '0;
        if (w_hit) begin
            o_probe.hit   = 1'b1;
            o_probe.eq    = r_eq;
            o_probe.cmax  = (r_count == C_COUNT_MAX);
            o_probe.cone  = (r_count == C_COUNT_ONE);
            o_probe.value = r_value;
        end
    end

endmodule

// File: design/mftu_chain.sv
// ----------------------------------------------------------------------------
// mftu_chain
// The row of cells, each wired to its left and right neighbour.
// ----------------------------------------------------------------------------
`include "multiset_floor_take_unit_assert.svh"

module mftu_chain (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mftu_pkg::t_ctrl  i_ctrl,
    output mftu_pkg::t_probe o_probe [mftu_pkg::C_CAPACITY],
    output logic             o_full
);
    import mftu_pkg::*;

    t_slot                 w_slot [C_CAPACITY];
    logic [C_CAPACITY-1:0] w_le;
    logic [C_CAPACITY-1:0] w_hit;
    logic [C_CAPACITY-1:0] w_valid;
    logic [C_CAPACITY-1:0] w_valid_inc;

    for (genvar i = 0; i < C_CAPACITY; i++) begin : g_cell
        t_slot w_left;
        t_slot w_right;
        logic  w_left_le;
        logic  w_right_le;

        if (i == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_le = 1'b1;
        end else begin : g_mid_left
            assign w_left    = w_slot[i-1];
            assign w_left_le = w_le[i-1];
        end

        if (i == C_CAPACITY - 1) begin : g_last
            assign w_right    = '0;
            assign w_right_le = 1'b0;
        end else begin : g_mid_right
            assign w_right    = w_slot[i+1];
            assign w_right_le = w_le[i+1];
        end

        mftu_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (i_ctrl),
            .i_left     (w_left),
            .i_left_le  (w_left_le),
            .i_right    (w_right),
            .i_right_le (w_right_le),
            .o_slot     (w_slot[i]),
            .o_le       (w_le[i]),
            .o_hit      (w_hit[i]),
            .o_probe    (o_probe[i])
        );

        assign w_valid[i] = w_slot[i].valid;
    end

    assign o_full      = w_valid[C_CAPACITY-1];
    assign w_valid_inc = w_valid + C_CAPACITY'(1);

    // Occupied cells always form one run starting at the first cell.
    `MFTU_ASSERT_ALWAYS(a_valid_run, (w_valid & w_valid_inc) == '0, "occupied cells not contiguous")
    // At most one cell may claim the floor of the key.
    `MFTU_ASSERT_ALWAYS(a_single_hit, $onehot0(w_hit), "more than one hit cell")

endmodule

// File: design/mftu_tree.sv
// ----------------------------------------------------------------------------
// mftu_tree
// Registered OR tree that gathers the report of the single hit cell.
// ----------------------------------------------------------------------------
module mftu_tree (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  mftu_pkg::t_probe i_probe [mftu_pkg::C_CAPACITY],
    output logic             o_valid,
    output mftu_pkg::t_probe o_result
);
    import mftu_pkg::*;

    t_probe                   r_node [C_TREE_LEVELS][C_TREE_W0];
    logic [C_TREE_LEVELS-1:0] r_vld;

    for (genvar l = 0; l < C_TREE_LEVELS; l++) begin : g_lvl
        for (genvar n = 0; n < C_TREE_W0; n++) begin : g_node
            if (n < f_tree_nodes(l)) begin : g_used
                t_probe w_kid [C_TREE_RADIX];
                t_probe w_or;

                for (genvar k = 0; k < C_TREE_RADIX; k++) begin : g_kid
                    if (l == 0) begin : g_leaf
                        if (n * C_TREE_RADIX + k < C_CAPACITY) begin : g_on
                            assign w_kid[k] = i_probe[n*C_TREE_RADIX+k];
                        end else begin : g_off
                            assign w_kid[k] = '0;
                        end
                    end else begin : g_inner
                        if (n * C_TREE_RADIX + k < f_tree_nodes(l - 1)) begin : g_on
                            assign w_kid[k] = r_node[l-1][n*C_TREE_RADIX+k];
                        end else begin : g_off
                            assign w_kid[k] = '0;
                        end
                    end
                end

                always_comb begin
                    w_or = '0;
                    for (int k = 0; k < C_TREE_RADIX; k++) begin
                        w_or = t_probe'(w_or | w_kid[k]);
                    end
                end

                always_ff @(posedge i_clk) begin
                    r_node[l][n] <= w_or;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= C_TREE_LEVELS'({r_vld, i_valid});
        end
    end

    assign o_valid  = r_vld[C_TREE_LEVELS-1];
    assign o_result = r_node[C_TREE_LEVELS-1][0];

endmodule

// File: design/multiset_floor_take_unit.sv
// ----------------------------------------------------------------------------
// multiset_floor_take_unit
// Bounded multiset of 32-bit values held in an ascending chain of cells.
// Inserts add a copy; takes remove one copy of the greatest value not above
// the given limit.
// ----------------------------------------------------------------------------
// Each item passes through S_CMP, S_PROBE, S_WAIT and S_UPD in turn; S_WAIT
// waits on the registered OR tree, 3 levels deep for 1024 cells. A new item is
// taken only in S_IDLE, or in S_UPD while the output is free; the compare, the
// tree walk and the shift of the cell chain are done in turn for each item.
// Reset: cell occupancy and all control clear at once; no clearing pass.
// ----------------------------------------------------------------------------
`include "multiset_floor_take_unit_assert.svh"

module multiset_floor_take_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_op,
    input  logic [mftu_pkg::C_VALUE_W-1:0]      i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mftu_pkg::C_STATUS_W-1:0]     o_status,
    output logic [mftu_pkg::C_VALUE_W-1:0]      o_taken_value
);
    import mftu_pkg::*;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [C_VALUE_W-1:0] r_key, n_key;
    t_probe               r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [C_VALUE_W-1:0] r_out_taken, n_out_taken;

    t_ctrl                w_ctrl;
    t_probe               w_probe [C_CAPACITY];
    logic                 w_full;
    logic                 w_tree_start;
    logic                 w_tree_valid;
    t_probe               w_tree_res;
    logic                 w_out_free;
    logic                 w_accept;

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) || ((r_state == S_UPD) && w_out_free));
    assign w_accept   = i_valid && !o_stall;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_key        = r_key;
        n_res        = r_res;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_taken  = r_out_taken;
        w_ctrl.cmp   = (r_state == S_CMP);
        w_ctrl.kind  = CMD_NONE;
        w_ctrl.key   = r_key;
        w_tree_start = (r_state == S_PROBE);

        if (w_accept) begin
            n_op  = t_op'(i_op);
            n_key = i_value;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_tree_valid) begin
                    n_res   = w_tree_res;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_taken = '0;
                    if (r_op == OP_INSERT) begin
                        if (r_res.hit && r_res.eq) begin
                            if (r_res.cmax) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_status = ST_INSERTED;
                                w_ctrl.kind  = CMD_INC;
                            end
                        end else if (w_full) begin
                            n_out_status = ST_FULL;
                        end else begin
                            n_out_status = ST_INSERTED;
                            w_ctrl.kind  = CMD_INSERT;
                        end
                    end else begin
                        if (r_res.hit) begin
                            n_out_status = ST_TAKEN;
                            n_out_taken  = r_res.value;
                            // The last copy frees the cell and closes the gap.
                            w_ctrl.kind  = r_res.cone ? CMD_REMOVE : CMD_DEC;
                        end else begin
                            n_out_status = ST_NONE;
                        end
                    end
                    n_state = w_accept ? S_CMP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_key        <= n_key;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_taken  <= n_out_taken;
    end

    mftu_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_probe (w_probe),
        .o_full  (w_full)
    );

    mftu_tree u_tree (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_tree_start),
        .i_probe  (w_probe),
        .o_valid  (w_tree_valid),
        .o_result (w_tree_res)
    );

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_taken_value = r_out_taken;

    // A successful take never returns a value above its limit.
    `MFTU_ASSERT_IMPLY(a_take_floor, (r_state == S_UPD) && (r_op == OP_TAKE) && r_res.hit, r_res.value <= r_key, "taken value above limit")
    // Only a successful take carries a non-zero value.
    `MFTU_ASSERT_IMPLY(a_zero_value, o_valid && (o_status != ST_TAKEN), o_taken_value == '0, "value on a non-take result")

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Testbench for multiset_floor_take_unit
// Drives insert and floor-take transactions through the valid/stall input
// channel, keeps its own model of the bounded multiset, and checks every
// result transaction field by field in order. Covers the extremes of the
// operand, the empty store, duplicates and last-copy removal, with random
// idling on both sides and one long hold-off at the output.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mftu_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_AT      = 300;
    localparam int QUIET_FROM   = 600;
    localparam int QUIET_TO     = 900;
    localparam int MIXED_ITEMS  = 970;
    localparam int DRAIN_ITEMS  = 60;
    localparam int TAIL_CYCLES  = 12;

    typedef struct packed {
        t_op                  op;
        logic [C_VALUE_W-1:0] value;
    } t_request;

    typedef struct packed {
        t_status              status;
        logic [C_VALUE_W-1:0] taken;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_op = 1'b0;
    logic [C_VALUE_W-1:0]  i_value = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [C_STATUS_W-1:0] o_status;
    logic [C_VALUE_W-1:0]  o_taken_value;

    // Stimulus and scoreboard state.
    t_request              pending_requests[$];
    t_outcome              awaited_results[$];
    logic [C_VALUE_W-1:0]  held_values[$];
    logic [C_COUNT_W-1:0]  held_counts[$];
    logic [C_VALUE_W-1:0]  hot_values[8];
    logic [C_VALUE_W-1:0]  inserted_values[$];

    int inputs_taken = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;
    int insert_count = 0;
    int take_count = 0;
    int peak_distinct = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int hold_left = 0;
    bit hold_done = 1'b0;

    multiset_floor_take_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_taken_value (o_taken_value)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Applies one transaction to the modelled multiset and returns its result.
    function automatic t_outcome apply_to_multiset(input t_op op, input logic [C_VALUE_W-1:0] val);
        t_outcome res;
        int       hit;
        int       last;
        hit = -1;
        res.taken = '0;
        if (op == OP_INSERT) begin
            foreach (held_values[i]) begin
                if (held_values[i] == val) hit = i;
            end
            if (hit >= 0) begin
                if (held_counts[hit] == C_COUNT_MAX) begin
                    res.status = ST_FULL;
                end else begin
                    held_counts[hit] = held_counts[hit] + C_COUNT_ONE;
                    res.status = ST_INSERTED;
                end
            end else if (held_values.size() >= C_CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                held_values = {held_values, val};
                held_counts = {held_counts, C_COUNT_ONE};
                res.status = ST_INSERTED;
            end
        end else begin
            foreach (held_values[i]) begin
                if (held_values[i] <= val && (hit < 0 || held_values[i] > held_values[hit])) begin
                    hit = i;
                end
            end
            if (hit < 0) begin
                res.status = ST_NONE;
            end else begin
                res.status = ST_TAKEN;
                res.taken = held_values[hit];
                held_counts[hit] = held_counts[hit] - C_COUNT_ONE;
                // The last copy frees its slot; the highest slot moves into the gap.
                if (held_counts[hit] == '0) begin
                    last = held_values.size() - 1;
                    held_values[hit] = held_values[last];
                    held_counts[hit] = held_counts[last];
                    void'(held_values.pop_back());
                    void'(held_counts.pop_back());
                end
            end
        end
        return res;
    endfunction

    function automatic bit idle_roll();
        bit quiet;
        quiet = inputs_taken >= QUIET_FROM && inputs_taken < QUIET_TO;
        return !quiet && ($urandom_range(99) < 7);
    endfunction

    task automatic add_request(input t_op op, input logic [C_VALUE_W-1:0] val);
        t_request req;
        req.op = op;
        req.value = val;
        pending_requests = {pending_requests, req};
        if (op == OP_INSERT) inserted_values = {inserted_values, val};
    endtask

    // Operands lean on a small pool so that values repeat and takes find something.
    function automatic logic [C_VALUE_W-1:0] pick_operand();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) return hot_values[$urandom_range(7)];
        if (roll < 65 && inserted_values.size() != 0) begin
            return inserted_values[$urandom_range(inserted_values.size() - 1)];
        end
        if (roll < 85) return $urandom;
        if (roll < 95) return C_VALUE_W'($urandom_range(15));
        return ($urandom_range(1) != 0) ? '1 : '0;
    endfunction

    function automatic logic [C_VALUE_W-1:0] pick_limit();
        logic [C_VALUE_W-1:0] base;
        int                   roll;
        base = pick_operand();
        roll = $urandom_range(99);
        if (roll < 30) return base;
        if (roll < 60) return base - 1;
        if (roll < 80) return base + C_VALUE_W'($urandom_range(255));
        if (roll < 90) return '1;
        return $urandom;
    endfunction

    // Driver: a new transaction is offered only once the previous one has gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_requests.size() != 0 && !idle_roll()) begin
                i_valid <= 1'b1;
                i_op    <= pending_requests[0].op;
                i_value <= pending_requests[0].value;
                void'(pending_requests.pop_front());
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with one long hold-off that backs the block up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && inputs_taken >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= idle_roll();
        end
    end

    // Monitor: predicts on each accepted input, checks each accepted result.
    always @(posedge i_clk) begin : monitor
        t_outcome want;
        bit       moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                awaited_results = {awaited_results, apply_to_multiset(t_op'(i_op), i_value)};
                inputs_taken <= inputs_taken + 1;
                if (t_op'(i_op) == OP_INSERT) insert_count++;
                else take_count++;
                if (held_values.size() > peak_distinct) peak_distinct = held_values.size();
            end
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                status_seen[o_status]++;
                if (awaited_results.size() == 0) begin
                    $error("Result transaction with nothing expected: status %0d, taken_value %h",
                           o_status, o_taken_value);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (o_status !== want.status) begin
                        $error("status: expected %0d (%s), actual %0d",
                               want.status, want.status.name(), o_status);
                        mismatch_count++;
                    end
                    if (o_taken_value !== want.taken) begin
                        $error("taken_value: expected %h, actual %h", want.taken, o_taken_value);
                        mismatch_count++;
                    end
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, awaited_results.size());
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        int roll;

        foreach (hot_values[k]) hot_values[k] = $urandom;

        // Directed: empty store, operand extremes, duplicates, last-copy removal.
        add_request(OP_TAKE,   32'hFFFF_FFFF);
        add_request(OP_INSERT, 32'h0000_0000);
        add_request(OP_INSERT, 32'hFFFF_FFFF);
        add_request(OP_INSERT, 32'hAAAA_AAAA);
        add_request(OP_INSERT, 32'h5555_5555);
        add_request(OP_INSERT, 32'h5555_5555);
        add_request(OP_TAKE,   32'h0000_0000);
        add_request(OP_TAKE,   32'h0000_0000);
        add_request(OP_TAKE,   32'h5555_5554);
        add_request(OP_TAKE,   32'h5555_5555);
        add_request(OP_TAKE,   32'hFFFF_FFFE);
        add_request(OP_TAKE,   32'hFFFF_FFFF);
        add_request(OP_TAKE,   32'hFFFF_FFFF);
        add_request(OP_TAKE,   32'hFFFF_FFFF);
        add_request(OP_INSERT, 32'h0000_0001);
        add_request(OP_INSERT, 32'h8000_0000);
        add_request(OP_INSERT, 32'h7FFF_FFFF);
        add_request(OP_TAKE,   32'h7FFF_FFFE);
        add_request(OP_TAKE,   32'h8000_0000);
        add_request(OP_TAKE,   32'hFFFF_FFFF);
        add_request(OP_TAKE,   32'hFFFF_FFFF);
        add_request(OP_TAKE,   32'hFFFF_FFFF);

        // Mixed traffic: the store grows in the first half and drains in the second.
        for (int n = 0; n < MIXED_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < ((n < MIXED_ITEMS / 2) ? 62 : 40)) add_request(OP_INSERT, pick_operand());
            else add_request(OP_TAKE, pick_limit());
        end

        // A closing run of takes empties most of what is left.
        for (int n = 0; n < DRAIN_ITEMS; n++) begin
            roll = $urandom_range(2);
            unique case (roll)
                0: add_request(OP_TAKE, pick_limit());
                1: add_request(OP_TAKE, '1);
                default: add_request(OP_TAKE, $urandom);
            endcase
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_requests.size() != 0 || i_valid || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Run covered %0d inserts and %0d takes; the store peaked at %0d distinct values.",
                 insert_count, take_count, peak_distinct);
        $display("Results seen: %0d inserted, %0d taken, %0d with nothing qualifying, %0d refused.",
                 status_seen[ST_INSERTED], status_seen[ST_TAKEN], status_seen[ST_NONE],
                 status_seen[ST_FULL]);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/mftu_pkg.sv
design/mftu_cell.sv
design/mftu_chain.sv
design/mftu_tree.sv
design/multiset_floor_take_unit.sv
dv/testbench.sv
